FILE: sv/ipv4_fht_pkg.sv
package ipv4_fht_pkg;

    localparam logic [4:0] HDR_BYTES = 5'd20;

    // result status codes
    typedef enum logic [2:0] {
        ST_PENDING  = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_BAD_LEN  = 3'd2,
        ST_TOO_BIG  = 3'd3,
        ST_OVERFLOW = 3'd4,
        ST_EXPIRED  = 3'd5,
        ST_QUIET    = 3'd6
    } t_status;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_CHK,
        S_SCAN,
        S_RIGHT,
        S_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic in_ready;
        logic accept;
        logic tick;
        logic len0;
        logic open;
        logic chk_err;
        logic scan_init;
        logic scan;
        logic right;
        logic done;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic in_valid;
        logic is_tick;
        logic len_zero;
        logic bad;
        logic ovf_scan;
        logic ovf_right;
        logic split;
        logic last_hole;
        logic out_free;
    } t_stat;

endpackage

FILE: sv/ipv4_fht_if.sv
interface ipv4_fht_frag_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [15:0] fragment_offset;
    logic [15:0] frag_len;
    logic        frag_more;
    modport source (output valid, cmd, fragment_offset, frag_len, frag_more,
                    input ready);
    modport sink (input valid, cmd, fragment_offset, frag_len, frag_more,
                  output ready);
endinterface

interface ipv4_fht_res_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] reasm_len;
    logic [4:0]  holes_open;
    modport source (output valid, status, reasm_len, holes_open, input ready);
    modport sink (input valid, status, reasm_len, holes_open, output ready);
endinterface

interface ipv4_fht_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

FILE: sv/ipv4_fragment_hole_tracker.sv
// Tracks reassembly of one IPv4 datagram with a hole list. Each input item is
// a fragment (offset, length, more-fragments) or a time tick, and gives one
// result item: status, total length when complete, and holes left. A tick or
// a zero-length fragment is answered from the decode state, a fragment that
// fails the length checks from the check state. Any other fragment passes
// decode and check, then takes a scan step per stored hole, one more step if
// it lies strictly inside a hole and splits it in two (only one hole can be
// split that way), then a commit step, since the hole list is walked one
// entry a cycle (a split entry adds a right step) through a single read port.
// A hole overflow ends the walk early. A finished result waits in an output
// register while the next item is taken; the next result waits until that one has been taken.
module ipv4_fragment_hole_tracker
    import ipv4_fht_pkg::*;
#(
    parameter int MAX_HOLES        = 16,
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ipv4_fht_frag_if.sink   i_frag,
    ipv4_fht_res_if.source  o_res,
    ipv4_fht_cfg_if.sink    i_cfg
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencing
    ipv4_fht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // hole list and context
    ipv4_fht_dp #(
        .MAX_HOLES        (MAX_HOLES),
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_frag  (i_frag),
        .o_res   (o_res),
        .i_cfg   (i_cfg),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

endmodule

FILE: sv/ipv4_fht_ctrl.sv
module ipv4_fht_ctrl
    import ipv4_fht_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.is_tick) begin
                    if (i_stat.out_free) begin
                        o_cmd.tick = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (i_stat.len_zero) begin
                    if (i_stat.out_free) begin
                        o_cmd.len0 = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_cmd.open = 1'b1;
                    n_state    = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.bad) begin
                    if (i_stat.out_free) begin
                        o_cmd.chk_err = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.ovf_scan) begin
                    if (i_stat.out_free) begin
                        o_cmd.scan = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_cmd.scan = 1'b1;
                    if (i_stat.split) begin
                        n_state = S_RIGHT;
                    end else if (i_stat.last_hole) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_RIGHT: begin
                if (i_stat.ovf_right) begin
                    if (i_stat.out_free) begin
                        o_cmd.right = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    o_cmd.right = 1'b1;
                    n_state     = i_stat.last_hole ? S_DONE : S_SCAN;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.done = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

FILE: sv/ipv4_fht_dp.sv
module ipv4_fht_dp
    import ipv4_fht_pkg::*;
#(
    parameter int MAX_HOLES        = 16,
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ipv4_fht_frag_if.sink   i_frag,
    ipv4_fht_res_if.source  o_res,
    ipv4_fht_cfg_if.sink    i_cfg,
    input  t_cmd  i_cmd,
    output t_stat o_stat
);

    localparam int IW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
    localparam int CW = $clog2(MAX_HOLES + 1);
    localparam logic [15:0] MAX_B  = 16'(MAX_PACKET_BYTES);
    localparam logic [CW-1:0] MAX_N = CW'(MAX_HOLES);

    // hole list, two banks swapped when a scan commits with holes left
    logic [15:0] r_hs [2][MAX_HOLES];
    logic [15:0] r_he [2][MAX_HOLES];

    logic          r_sel;
    logic [CW-1:0] r_count;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_n;
    logic          r_active;
    logic [15:0]   r_age;
    logic [15:0]   r_dlen;
    logic [15:0]   r_life;

    // captured item
    logic        r_cmd;
    logic [15:0] r_first;
    logic [15:0] r_len;
    logic        r_mf;

    // output register
    logic        r_ovalid;
    t_status     r_ostatus;
    logic [15:0] r_ototal;
    logic [4:0]  r_oholes;

    logic [16:0] w_last;
    logic [17:0] w_end;
    logic [15:0] w_hs;
    logic [15:0] w_he;
    logic        w_overlap;
    logic        w_left;
    logic        w_right;
    logic        w_wr0;
    logic [15:0] w_ws;
    logic [15:0] w_we;
    logic        w_bad_mult;
    logic [15:0] w_age_inc;
    logic        w_out_free;
    logic        w_res_load;

    // fragment span and hole compare
    assign w_last    = {1'b0, r_first} + {1'b0, r_len} - 17'd1;
    assign w_end     = {1'b0, w_last} + 18'd1 + 18'(HDR_BYTES);
    assign w_hs      = r_hs[r_sel][r_idx];
    assign w_he      = r_he[r_sel][r_idx];
    assign w_overlap = !(({1'b0, r_first} > {1'b0, w_he}) || (w_last < {1'b0, w_hs}));
    assign w_left    = r_first > w_hs;
    assign w_right   = (w_last < {1'b0, w_he}) && r_mf;
    assign w_wr0     = !w_overlap || w_left || w_right;
    assign w_bad_mult = r_mf && (r_len[2:0] != 3'd0);
    assign w_age_inc = (r_age == 16'hFFFF) ? r_age : r_age + 16'd1;
    assign w_out_free = !r_ovalid || o_res.ready;

    // a new result is loaded into the output register this cycle
    assign w_res_load = i_cmd.tick || i_cmd.len0 || i_cmd.chk_err || i_cmd.done
                        || (i_cmd.scan && w_wr0 && (r_n == MAX_N))
                        || (i_cmd.right && (r_n == MAX_N));

    // phase-0 write data for the current hole
    always_comb begin
        if (!w_overlap) begin
            w_ws = w_hs;
            w_we = w_he;
        end else if (w_left) begin
            w_ws = w_hs;
            w_we = r_first - 16'd1;
        end else begin
            w_ws = w_last[15:0] + 16'd1;
            w_we = w_he;
        end
    end

    // status to controller
    always_comb begin
        o_stat.in_valid  = i_frag.valid;
        o_stat.is_tick   = r_cmd;
        o_stat.len_zero  = (r_len == 16'd0);
        o_stat.bad       = w_bad_mult || (w_end > 18'(MAX_PACKET_BYTES));
        o_stat.ovf_scan  = w_wr0 && (r_n == MAX_N);
        o_stat.ovf_right = (r_n == MAX_N);
        o_stat.split     = w_overlap && w_left && w_right;
        o_stat.last_hole = (CW'(r_idx) + CW'(1)) == r_count;
        o_stat.out_free  = w_out_free;
    end

    assign i_frag.ready      = i_cmd.in_ready;
    assign i_cfg.ready       = 1'b1;
    assign o_res.valid        = r_ovalid;
    assign o_res.status       = r_ostatus;
    assign o_res.reasm_len    = r_ototal;
    assign o_res.holes_open   = r_oholes;

    // hole storage writes
    always_ff @(posedge i_clk) begin
        if (i_cmd.open && !r_active) begin
            r_hs[r_sel][0] <= 16'd0;
            r_he[r_sel][0] <= MAX_B;
        end else if (i_cmd.scan && w_wr0 && (r_n != MAX_N)) begin
            r_hs[!r_sel][r_n[IW-1:0]] <= w_ws;
            r_he[!r_sel][r_n[IW-1:0]] <= w_we;
        end else if (i_cmd.right && (r_n != MAX_N)) begin
            r_hs[!r_sel][r_n[IW-1:0]] <= w_last[15:0] + 16'd1;
            r_he[!r_sel][r_n[IW-1:0]] <= w_he;
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd   <= i_frag.cmd;
            r_first <= i_frag.fragment_offset;
            r_len   <= i_frag.frag_len;
            r_mf    <= i_frag.frag_more;
        end
    end

    // context and result control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel     <= 1'b0;
            r_count   <= '0;
            r_idx     <= '0;
            r_n       <= '0;
            r_active  <= 1'b0;
            r_age     <= '0;
            r_dlen    <= '0;
            r_life    <= 16'd60;
            r_ovalid  <= 1'b0;
            r_ostatus <= ST_PENDING;
            r_ototal  <= '0;
            r_oholes  <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_life <= i_cfg.data;
            end
            if (r_ovalid && o_res.ready && !w_res_load) begin
                r_ovalid <= 1'b0;
            end
            // tick ages the context, or expires it at its lifetime
            if (i_cmd.tick) begin
                r_ovalid <= 1'b1;
                r_ototal <= '0;
                if (!r_active) begin
                    r_ostatus <= ST_QUIET;
                    r_oholes  <= '0;
                end else if (w_age_inc >= r_life) begin
                    r_active  <= 1'b0;
                    r_count   <= '0;
                    r_age     <= '0;
                    r_dlen    <= '0;
                    r_ostatus <= ST_EXPIRED;
                    r_oholes  <= '0;
                end else begin
                    r_age     <= w_age_inc;
                    r_ostatus <= ST_QUIET;
                    r_oholes  <= 5'(r_count);
                end
            end
            // zero-length fragment leaves context untouched
            if (i_cmd.len0) begin
                r_ovalid  <= 1'b1;
                r_ostatus <= ST_BAD_LEN;
                r_ototal  <= '0;
                r_oholes  <= 5'(r_count);
            end
            // open a fresh context with one hole
            if (i_cmd.open && !r_active) begin
                r_active <= 1'b1;
                r_count  <= CW'(1);
                r_age    <= '0;
                r_dlen   <= '0;
            end
            if (i_cmd.scan_init) begin
                r_idx <= '0;
                r_n   <= '0;
            end
            // length checks failed
            if (i_cmd.chk_err) begin
                r_active  <= 1'b0;
                r_count   <= '0;
                r_age     <= '0;
                r_dlen    <= '0;
                r_ovalid  <= 1'b1;
                r_ostatus <= w_bad_mult ? ST_BAD_LEN : ST_TOO_BIG;
                r_ototal  <= '0;
                r_oholes  <= '0;
            end
            // one hole, left or pass-through part
            if (i_cmd.scan) begin
                if (w_wr0 && (r_n == MAX_N)) begin
                    r_active  <= 1'b0;
                    r_count   <= '0;
                    r_age     <= '0;
                    r_dlen    <= '0;
                    r_ovalid  <= 1'b1;
                    r_ostatus <= ST_OVERFLOW;
                    r_ototal  <= '0;
                    r_oholes  <= '0;
                end else begin
                    if (w_wr0) begin
                        r_n <= r_n + CW'(1);
                    end
                    if (!(w_overlap && w_left && w_right)) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
            end
            // right part of a split hole
            if (i_cmd.right) begin
                if (r_n == MAX_N) begin
                    r_active  <= 1'b0;
                    r_count   <= '0;
                    r_age     <= '0;
                    r_dlen    <= '0;
                    r_ovalid  <= 1'b1;
                    r_ostatus <= ST_OVERFLOW;
                    r_ototal  <= '0;
                    r_oholes  <= '0;
                end else begin
                    r_n   <= r_n + CW'(1);
                    r_idx <= r_idx + IW'(1);
                end
            end
            // commit new list and report
            if (i_cmd.done) begin
                r_ovalid <= 1'b1;
                if (r_n == '0) begin
                    r_active  <= 1'b0;
                    r_count   <= '0;
                    r_age     <= '0;
                    r_dlen    <= '0;
                    r_ostatus <= ST_COMPLETE;
                    r_ototal  <= r_mf ? r_dlen : w_end[15:0];
                    r_oholes  <= '0;
                end else begin
                    r_sel     <= !r_sel;
                    r_count   <= r_n;
                    if (!r_mf) begin
                        r_dlen <= w_end[15:0];
                    end
                    r_ostatus <= ST_PENDING;
                    r_ototal  <= '0;
                    r_oholes  <= 5'(r_n);
                end
            end
        end
    end

endmodule
